// File: rtl/sequenced_ring_slot_manager_assert.svh
// ----------------------------------------------------------------------------
// sequenced ring slot manager assertion macros
// property wrappers on clk with rst_n as the disable condition
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_RING_SLOT_MANAGER_ASSERT_SVH
`define SEQUENCED_RING_SLOT_MANAGER_ASSERT_SVH

// same-cycle implication
`define SRSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srsm_pkg.sv
// ----------------------------------------------------------------------------
// srsm_pkg
// operation and status codes, field widths and defaults of the slot manager
// ----------------------------------------------------------------------------
package srsm_pkg;

    localparam int CAPACITY_DEFAULT = 8;
    localparam int POS_BITS_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int TICKET_W = 32;
    localparam int POS_W    = 32;
    localparam int SLOT_W   = 3;
    localparam int BYTE_W   = 15;
    localparam int HALF_W   = 14;
    localparam int CHUNK_W  = 13;
    localparam int OUT_W    = POS_W + SLOT_W + BYTE_W + HALF_W;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd64;

    localparam logic [OP_W-1:0] OP_PCLAIM   = 3'd0;
    localparam logic [OP_W-1:0] OP_PCOMMIT  = 3'd1;
    localparam logic [OP_W-1:0] OP_CCLAIM   = 3'd2;
    localparam logic [OP_W-1:0] OP_CRELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHUT_DOWN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STALE     = 2'd3;

endpackage

// File: rtl/sequenced_ring_slot_manager.sv
// ----------------------------------------------------------------------------
// sequenced_ring_slot_manager
// slot bookkeeping of a power-of-two ring with one sequence number per slot
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls and returns one result
// item per item via the input register and then the result register. The
// rate is set by the single execute stage that reads one slot sequence,
// compares it with the head or tail position and writes back the sequence
// table and positions in the same cycle; sequence flip-flops reset to the slot
// number, so no clearing pass is needed. The user writes chunk_bytes through
// the always-ready cfg channel only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "sequenced_ring_slot_manager_assert.svh"

module sequenced_ring_slot_manager
    import srsm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CHUNK_W-1:0]  cfg_data,       // chunk_bytes
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TICKET_W-1:0] s_axis_tdata,   // ticket_position
    input  logic [OP_W-1:0]     s_axis_tuser,   // operation
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // position, slot_index, byte_offset,
                                                // halfword_offset
    output logic [STATUS_W-1:0] m_axis_tuser    // status
);

    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int BPROD_W   = SLOT_BITS + CHUNK_W;
    localparam int HPROD_W   = SLOT_BITS + CHUNK_W - 1;

    // state
    logic [POS_BITS-1:0]  seq_reg [CAPACITY];
    logic [POS_BITS-1:0]  head_reg;
    logic [POS_BITS-1:0]  tail_reg;
    logic                 shut_down_reg;
    logic [CHUNK_W-1:0]   chunk_reg;

    // input register
    logic                 in_valid_reg;
    logic [OP_W-1:0]      in_op_reg;
    logic [POS_BITS-1:0]  in_ticket_reg;

    // result register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [HALF_W-1:0]    out_half_reg;

    // execute stage
    logic                 advance;
    logic                 exec;
    logic [SLOT_BITS-1:0] rd_slot;
    logic [POS_BITS-1:0]  seq_rd;
    logic [SLOT_BITS-1:0] ticket_slot;
    logic [POS_BITS-1:0]  head_inc;
    logic [POS_BITS-1:0]  tail_inc;
    logic [POS_BITS-1:0]  ticket_inc;
    logic [POS_BITS-1:0]  ticket_lap;
    logic [POS_BITS-1:0]  grant_pos;
    logic [SLOT_BITS-1:0] grant_slot;
    logic [CHUNK_W-2:0]   half_raw;
    logic [CHUNK_W-2:0]   half_chunk;
    logic [BPROD_W-1:0]   byte_prod;
    logic [HPROD_W-1:0]   half_prod;

    logic                 grant;
    logic [STATUS_W-1:0]  status_next;
    logic                 seq_we;
    logic [POS_BITS-1:0]  seq_wdata;
    logic                 head_we;
    logic                 tail_we;
    logic                 shut_set;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign exec          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign rd_slot     = (in_op_reg == OP_CCLAIM) ? head_reg[SLOT_BITS-1:0]
                                                  : tail_reg[SLOT_BITS-1:0];
    assign seq_rd      = seq_reg[rd_slot];
    assign ticket_slot = in_ticket_reg[SLOT_BITS-1:0];
    assign head_inc    = head_reg + POS_BITS'(1);
    assign tail_inc    = tail_reg + POS_BITS'(1);
    assign ticket_inc  = in_ticket_reg + POS_BITS'(1);
    assign ticket_lap  = in_ticket_reg + POS_BITS'(CAPACITY);

    assign grant_pos  = (in_op_reg == OP_CCLAIM) ? head_reg : tail_reg;
    assign grant_slot = grant_pos[SLOT_BITS-1:0];
    assign half_raw   = chunk_reg[CHUNK_W-1:1];
    assign half_chunk = (half_raw == '0) ? (CHUNK_W-1)'(1) : half_raw;
    assign byte_prod  = BPROD_W'(grant_slot) * BPROD_W'(chunk_reg);
    assign half_prod  = HPROD_W'(grant_slot) * HPROD_W'(half_chunk);

    always_comb
    begin
        grant       = 1'b0;
        status_next = ST_DONE;
        seq_we      = 1'b0;
        seq_wdata   = ticket_inc;
        head_we     = 1'b0;
        tail_we     = 1'b0;
        shut_set    = 1'b0;
        unique case (in_op_reg)
            OP_PCLAIM:
            begin
                if (shut_down_reg)
                begin
                    status_next = ST_SHUT_DOWN;
                end
                else if (seq_rd == tail_reg)
                begin
                    grant = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_READY;
                end
            end
            OP_PCOMMIT:
            begin
                if (in_ticket_reg == tail_reg)
                begin
                    tail_we = 1'b1;
                    seq_we  = 1'b1;
                end
                else
                begin
                    status_next = ST_STALE;
                end
            end
            OP_CCLAIM:
            begin
                if (seq_rd == head_inc)
                begin
                    grant   = 1'b1;
                    head_we = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_READY;
                end
            end
            OP_CRELEASE:
            begin
                seq_we    = 1'b1;
                seq_wdata = ticket_lap;
            end
            OP_STOP:
            begin
                shut_set = 1'b1;
            end
            default:
            begin
                status_next = ST_NOT_READY;
            end
        endcase
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            chunk_reg <= cfg_data;
        end
    end

    // ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                seq_reg[i] <= POS_BITS'(i);
            end
            head_reg      <= '0;
            tail_reg      <= '0;
            shut_down_reg <= 1'b0;
        end
        else if (exec)
        begin
            if (seq_we)
            begin
                seq_reg[ticket_slot] <= seq_wdata;
            end
            if (head_we)
            begin
                head_reg <= head_inc;
            end
            if (tail_we)
            begin
                tail_reg <= tail_inc;
            end
            if (shut_set)
            begin
                shut_down_reg <= 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg     <= s_axis_tuser;
            in_ticket_reg <= POS_BITS'(s_axis_tdata);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_status_reg <= status_next;
            if (grant)
            begin
                out_pos_reg  <= POS_W'(grant_pos);
                out_slot_reg <= SLOT_W'(grant_slot);
                out_byte_reg <= BYTE_W'(byte_prod);
                out_half_reg <= HALF_W'(half_prod);
            end
            else
            begin
                out_pos_reg  <= '0;
                out_slot_reg <= '0;
                out_byte_reg <= '0;
                out_half_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_half_reg, out_byte_reg, out_slot_reg, out_pos_reg};

    // checks
    `SRSM_ASSERT_NOW(a_fail_no_payload, m_axis_tvalid && (m_axis_tuser != ST_DONE),
        m_axis_tdata == '0, "failed operation carries a non-zero payload")
    `SRSM_ASSERT_NEXT(a_shut_down_sticky, shut_down_reg, shut_down_reg,
        "shut down flag cleared after being set")
    `SRSM_ASSERT_NEXT(a_head_step, 1'b1,
        (head_reg == $past(head_reg)) || (head_reg == $past(head_reg) + POS_BITS'(1)),
        "head position moved by more than one")

endmodule
